[hw/rtl/two_level_page_table_store_macros.svh]
// Assertion helpers for the page table store RTL
`ifndef TWO_LEVEL_PAGE_TABLE_STORE_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_STORE_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define TLPT_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger
`define TLPT_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[hw/rtl/tlpt_pkg.sv]
package tlpt_pkg;

    // Table geometry
    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int DIR_IDX_W     = $clog2(DIR_ENTRIES);
    localparam int TAB_IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int TAB_ADDR_W    = DIR_IDX_W + TAB_IDX_W;
    localparam int TAB_WORDS     = DIR_ENTRIES * TABLE_ENTRIES;

    // Stream widths
    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 72;

    // x86 entry flags and masks
    localparam logic [31:0] FLAG_P     = 32'h0000_0001;
    localparam logic [31:0] FLAG_RW    = 32'h0000_0002;
    localparam logic [31:0] FLAG_US    = 32'h0000_0004;
    localparam logic [31:0] FLAG_PS    = 32'h0000_0080;
    localparam logic [31:0] LARGE_MASK = 32'hFFC0_0000;
    localparam logic [31:0] SMALL_MASK = 32'hFFFF_F000;

    // Configuration
    localparam logic        REG_TABLE_AREA_BASE = 1'b0;
    localparam logic [31:0] TABLE_AREA_RESET    = 32'h0080_0000;

    // User ring
    localparam logic [1:0] RING_USER = 2'd3;

    // Request kinds
    typedef enum logic [2:0] {
        KIND_MAP_LARGE   = 3'd0,
        KIND_MAP_SMALL   = 3'd1,
        KIND_UNMAP_SMALL = 3'd2,
        KIND_UNMAP_LARGE = 3'd3,
        KIND_QUERY       = 3'd4
    } kind_t;

    // Access to the page table memory
    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [TAB_ADDR_W-1:0] addr;
        logic [31:0]           wdata;
    } tab_req_t;

endpackage

[hw/rtl/tlpt_table_ram.sv]
module tlpt_table_ram
(
    input  logic               clk,
    input  tlpt_pkg::tab_req_t req,
    output logic [31:0]        rdata
);
    import tlpt_pkg::*;

    logic [31:0] mem [TAB_WORDS];
    logic [31:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/two_level_page_table_store.sv]
// Channel   Dir  Handshake              Contents
// s_axis    in   s_axis_tvalid/tready   one request (kind in tuser)
// m_axis    out  m_axis_tvalid/tready   one query answer
// apb       in   psel/penable/pready    table_area_base at address 0
//
// Steps: each request is accepted, then its directory word is read; a query of
// a 4 KB mapping adds a page table memory read. Mapping a 4 KB page over a
// 4 MB entry walks the whole table.
// Reset: a pass writes every directory word to large-absent;
// s_axis_tready stays low until it ends.
// Stalls: the answer sits in an output register; new requests are taken while
// it waits, and a later query holds in its last state until the register frees.
`include "two_level_page_table_store_macros.svh"

module two_level_page_table_store
(
    input  logic                              clk,
    input  logic                              rst_n,
    // s_axis_tdata: virt_addr[31:0], phys_addr[63:32], privilege_level[65:64], zero fill
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tlpt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: kind[2:0]
    input  logic [tlpt_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // m_axis_tdata: present[0], user[1], dir_word[33:2], table_word[65:34], zero fill
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tlpt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import tlpt_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DIR,
        S_TAB,
        S_CLEAR,
        S_MAP
    } state_t;

    state_t                 state_reg;
    logic [DIR_IDX_W-1:0]   walk_cnt_reg;
    logic [31:0]            base_reg;

    // Latched request
    logic [2:0]             kind_reg;
    logic [DIR_IDX_W-1:0]   di_reg;
    logic [TAB_IDX_W-1:0]   ti_reg;
    logic [31:0]            pa_reg;
    logic [1:0]             priv_reg;

    // Directory memory
    logic [31:0]            dir_mem [DIR_ENTRIES];
    logic [31:0]            dir_rdata_reg;
    logic                   dir_we;
    logic                   dir_re;
    logic [DIR_IDX_W-1:0]   dir_addr;
    logic [31:0]            dir_wdata;

    // Page table memory
    tab_req_t               tab_req;
    logic [31:0]            tab_rdata;

    // Result register
    logic                   out_valid_reg;
    logic                   present_reg;
    logic                   user_reg;
    logic [31:0]            dir_word_reg;
    logic [31:0]            table_word_reg;

    logic                   accept;
    logic                   out_free;
    logic [31:0]            us_flag;
    logic [31:0]            taddr;
    logic [31:0]            large_dir_word;
    logic [31:0]            small_dir_word;
    logic [31:0]            small_tab_word;
    logic                   is_large;
    logic                   need_tab;
    logic [31:0]            t_word;
    logic                   res_present;
    logic                   res_user;
    logic                   load_out;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // New entry words
    assign us_flag        = (priv_reg == RING_USER) ? FLAG_US : '0;
    assign taddr          = (base_reg & SMALL_MASK) + {di_reg, 22'd0} / 32'd1024;
    assign large_dir_word = (pa_reg & LARGE_MASK) | FLAG_P | FLAG_RW | FLAG_PS | us_flag;
    assign small_dir_word = (taddr & SMALL_MASK) | FLAG_P | FLAG_RW | us_flag;
    assign small_tab_word = (pa_reg & SMALL_MASK) | FLAG_P | FLAG_RW | us_flag;

    // Query answer
    assign is_large    = dir_rdata_reg[7];
    assign need_tab    = !is_large && dir_rdata_reg[0];
    assign t_word      = (state_reg == S_TAB) ? tab_rdata : '0;
    assign res_present = dir_rdata_reg[0] && (is_large || t_word[0]);
    assign res_user    = res_present && dir_rdata_reg[2] && (is_large || t_word[2]);

    // Memory access decode
    always_comb
    begin
        dir_we        = 1'b0;
        dir_re        = 1'b0;
        dir_addr      = di_reg;
        dir_wdata     = FLAG_PS;
        tab_req.we    = 1'b0;
        tab_req.re    = 1'b0;
        tab_req.addr  = {di_reg, ti_reg};
        tab_req.wdata = '0;
        load_out      = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                dir_we   = 1'b1;
                dir_addr = walk_cnt_reg;
            end
            S_IDLE:
            begin
                dir_re   = accept;
                dir_addr = s_axis_tdata[31:32-DIR_IDX_W];
            end
            S_DIR:
            begin
                case (kind_reg)
                    KIND_MAP_LARGE:
                    begin
                        dir_we    = 1'b1;
                        dir_wdata = large_dir_word;
                    end
                    KIND_MAP_SMALL:
                    begin
                        if (!is_large)
                        begin
                            dir_we        = 1'b1;
                            dir_wdata     = small_dir_word;
                            tab_req.we    = 1'b1;
                            tab_req.wdata = small_tab_word;
                        end
                    end
                    KIND_UNMAP_SMALL:
                    begin
                        tab_req.we = 1'b1;
                    end
                    KIND_UNMAP_LARGE:
                    begin
                        dir_we = 1'b1;
                    end
                    KIND_QUERY:
                    begin
                        tab_req.re = need_tab;
                        load_out   = !need_tab && out_free;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_TAB:
            begin
                load_out = out_free;
            end
            S_CLEAR:
            begin
                tab_req.we   = 1'b1;
                tab_req.addr = {di_reg, walk_cnt_reg};
            end
            S_MAP:
            begin
                dir_we        = 1'b1;
                dir_wdata     = small_dir_word;
                tab_req.we    = 1'b1;
                tab_req.wdata = small_tab_word;
            end
            default:
            begin
            end
        endcase
    end

    // Directory memory, registered read
    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_addr] <= dir_wdata;
        end
        if (dir_re)
        begin
            dir_rdata_reg <= dir_mem[dir_addr];
        end
    end

    tlpt_table_ram u_table_ram
    (
        .clk   (clk),
        .req   (tab_req),
        .rdata (tab_rdata)
    );

    // Request latch and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_axis_tuser;
            di_reg   <= s_axis_tdata[31:32-DIR_IDX_W];
            ti_reg   <= s_axis_tdata[31-DIR_IDX_W:32-DIR_IDX_W-TAB_IDX_W];
            pa_reg   <= s_axis_tdata[63:32];
            priv_reg <= s_axis_tdata[65:64];
        end
        if (load_out)
        begin
            present_reg    <= res_present;
            user_reg       <= res_user;
            dir_word_reg   <= dir_rdata_reg;
            table_word_reg <= t_word;
        end
    end

    // Sequencer, walk counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            walk_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    walk_cnt_reg <= walk_cnt_reg + 1'b1;
                    if (walk_cnt_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_DIR;
                    end
                end
                S_DIR:
                begin
                    case (kind_reg)
                        KIND_MAP_SMALL:
                        begin
                            walk_cnt_reg <= '0;
                            state_reg    <= is_large ? S_CLEAR : S_IDLE;
                        end
                        KIND_QUERY:
                        begin
                            if (need_tab)
                            begin
                                state_reg <= S_TAB;
                            end
                            else if (out_free)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_TAB:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CLEAR:
                begin
                    walk_cnt_reg <= walk_cnt_reg + 1'b1;
                    if (walk_cnt_reg == '1)
                    begin
                        state_reg <= S_MAP;
                    end
                end
                S_MAP:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= TABLE_AREA_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_TABLE_AREA_BASE))
        begin
            base_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TABLE_AREA_BASE) ? base_reg : '0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, table_word_reg, dir_word_reg, user_reg, present_reg};

    `TLPT_ASSERT_NEXT(a_accept_reads_dir, clk, rst_n, accept, state_reg == S_DIR, "request not followed by directory lookup")
    `TLPT_ASSERT_NEXT(a_clear_ends_in_map, clk, rst_n, (state_reg == S_CLEAR) && (walk_cnt_reg == '1), state_reg == S_MAP, "table clear did not finish with the map write")
    `TLPT_ASSERT_SAME(a_tab_port_exclusive, clk, rst_n, tab_req.we, !tab_req.re && !dir_re, "page table write collides with a read")

endmodule

[bench/two_level_page_table_store_check.sv]
`timescale 1ns / 100ps

module two_level_page_table_store_check
(
    input  logic                             clk,
    input  logic                             rst_n,
    // s_axis_tdata: virt_addr[31:0], phys_addr[63:32], privilege_level[65:64], zero fill
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [tlpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: kind[2:0]
    input  logic [tlpt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    // m_axis_tdata: present[0], user[1], dir_word[33:2], table_word[65:34], zero fill
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [tlpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    input  logic [31:0]                      prdata,
    input  logic                             pready,
    output int                               pending_lookups,
    output int                               mismatches
);
    import tlpt_pkg::*;

    localparam logic [2:0] BASE_REG_ADDR = {REG_TABLE_AREA_BASE, 2'b00};

    typedef struct packed {
        logic        present;
        logic        user;
        logic [31:0] dir_word;
        logic [31:0] table_word;
    } lookup_t;

    // Shadow of the block's state
    logic [31:0] area_base;
    logic [31:0] dir_words [DIR_ENTRIES];
    logic [31:0] small_pages [bit [TAB_ADDR_W-1:0]];
    lookup_t     lookup_answers [$];
    int          fail_count = 0;

    assign mismatches = fail_count;

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, got %h", field, want, got);
            fail_count++;
        end
    endfunction

    // Applies one request to the shadow tables; a lookup queues its answer
    function automatic void apply_page_request(input logic [2:0] code, input logic [31:0] va,
                                               input logic [31:0] pa, input logic [1:0] ring);
        logic [DIR_IDX_W-1:0]  di;
        logic [TAB_IDX_W-1:0]  ti;
        logic [TAB_ADDR_W-1:0] slot;
        logic [31:0]           us;
        logic [31:0]           d;
        logic [31:0]           t;
        logic [31:0]           taddr;
        logic                  is_large;
        lookup_t               ans;
        di   = va[31:22];
        ti   = va[21:12];
        slot = {di, ti};
        us   = (ring == RING_USER) ? FLAG_US : 32'h0;
        case (kind_t'(code))
            KIND_MAP_LARGE:
                dir_words[di] = (pa & LARGE_MASK) | FLAG_P | FLAG_RW | FLAG_PS | us;
            KIND_MAP_SMALL:
            begin
                // leaving large mode wipes the whole table
                if ((dir_words[di] & FLAG_PS) != 0)
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        small_pages.delete({di, TAB_IDX_W'(i)});
                taddr = (area_base & SMALL_MASK) + 32'({di, 12'h000});
                dir_words[di]     = (taddr & SMALL_MASK) | FLAG_P | FLAG_RW | us;
                small_pages[slot] = (pa & SMALL_MASK) | FLAG_P | FLAG_RW | us;
            end
            KIND_UNMAP_SMALL:
                small_pages[slot] = 32'h0;
            KIND_UNMAP_LARGE:
                dir_words[di] = FLAG_PS;
            KIND_QUERY:
            begin
                d        = dir_words[di];
                is_large = (d & FLAG_PS) != 0;
                t        = (!is_large && (d & FLAG_P) != 0 && small_pages.exists(slot))
                           ? small_pages[slot] : 32'h0;
                ans.present    = (d & FLAG_P) != 0 && (is_large || (t & FLAG_P) != 0);
                ans.user       = ans.present && (d & FLAG_US) != 0
                                 && (is_large || (t & FLAG_US) != 0);
                ans.dir_word   = d;
                ans.table_word = t;
                lookup_answers.push_back(ans);
            end
            default: ;  // undefined kinds leave everything as it is
        endcase
    endfunction

    // Watch all three ports at each edge
    always @(posedge clk)
    begin : watch
        lookup_t want;
        if (!rst_n)
        begin
            area_base = TABLE_AREA_RESET;
            for (int i = 0; i < DIR_ENTRIES; i++)
                dir_words[i] = FLAG_PS;
            small_pages.delete();
            lookup_answers.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr == BASE_REG_ADDR)
            begin
                if (pwrite)
                    area_base = pwdata;
                else
                    check_field("table_area_base", area_base, prdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (lookup_answers.size() == 0)
                begin
                    $error("lookup answer with no query outstanding: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = lookup_answers.pop_front();
                    check_field("present", 32'(want.present), 32'(m_axis_tdata[0]));
                    check_field("user", 32'(want.user), 32'(m_axis_tdata[1]));
                    check_field("dir_word", want.dir_word, m_axis_tdata[33:2]);
                    check_field("table_word", want.table_word, m_axis_tdata[65:34]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_page_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                                   s_axis_tdata[65:64]);
        end
        pending_lookups <= lookup_answers.size();
    end

endmodule

[bench/two_level_page_table_store_test.sv]
`timescale 1ns / 100ps

module two_level_page_table_store_test;
    import tlpt_pkg::*;

    localparam logic [2:0] BASE_REG_ADDR  = {REG_TABLE_AREA_BASE, 2'b00};
    localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    // longest silent stretch of the block is the table walk
    localparam int SETTLE_CYCLES  = 1100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_REQUESTS = 360;

    logic                   clk;
    logic                   rst_n;
    // s_axis_tdata: virt_addr[31:0], phys_addr[63:32], privilege_level[65:64], zero fill
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // s_axis_tuser: kind[2:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    // m_axis_tdata: present[0], user[1], dir_word[33:2], table_word[65:34], zero fill
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    int pending_lookups;
    int mismatches;

    bit          calm;
    int          ready_hold = 0;
    int          stall_roll;
    int          idle_cycles = 0;
    logic [9:0]  hot_dirs [8];
    logic [9:0]  hot_slots [4];
    int          n_requests;
    int          n_lookups;
    int          n_ignored;
    int          n_bases;

    two_level_page_table_store u_top (.*);

    two_level_page_table_store_check u_check (.*);

    always #10 clk = ~clk;

    // Answer side: random stalls, mostly short, now and then long
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (calm)
            m_axis_tready <= 1'b1;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 60)
            begin
                m_axis_tready <= 1'b1;
                ready_hold    <= $urandom_range(0, 5);
            end
            else if (stall_roll < 95)
            begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(0, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_hold    <= $urandom_range(10, 120);
            end
        end
    end

    // Watchdog on cycles with no transfer on any port
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One request, after a random gap unless in a calm stretch
    task automatic send_request(input logic [2:0] code, input logic [31:0] va,
                                input logic [31:0] pa, input logic [1:0] ring);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            gap = 0;
        else if (roll < 85)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 80);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({ring, pa, va});
        s_axis_tuser  <= code;
        do @(posedge clk); while (!s_axis_tready);
        if (code == KIND_QUERY)
            n_lookups++;
        if (code > KIND_QUERY)
            n_ignored++;
        else
            n_requests++;
    endtask

    // Random request, mostly aimed at a few hot directory and table slots
    task automatic random_request(output bit counted);
        logic [2:0] code;
        logic [9:0] di;
        logic [9:0] ti;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            code = KIND_MAP_LARGE;
        else if (roll < 12)
            code = KIND_UNMAP_LARGE;
        else if (roll < 40)
            code = KIND_MAP_SMALL;
        else if (roll < 55)
            code = KIND_UNMAP_SMALL;
        else if (roll < 97)
            code = KIND_QUERY;
        else
            code = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        di = ($urandom_range(0, 99) < 85) ? hot_dirs[$urandom_range(0, 7)] : 10'($urandom);
        ti = ($urandom_range(0, 99) < 70) ? hot_slots[$urandom_range(0, 3)] : 10'($urandom);
        send_request(code, {di, ti, 12'($urandom)}, $urandom, 2'($urandom));
        counted = code <= KIND_QUERY;
    endtask

    // Stop sending and wait for every lookup answer
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_lookups != 0);
    endtask

    // Drain, then let any table walk finish
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_REG_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= BASE_REG_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // New table area base, then a block of random requests
    task automatic run_phase(input logic [31:0] base, input bit calm_lead);
        int done;
        bit counted;
        settle();
        apb_write(base);
        apb_read();
        n_bases++;
        done = 0;
        while (done < PHASE_REQUESTS)
        begin
            calm = calm_lead && done < 60;
            if (done == PHASE_REQUESTS / 2)
                drain();
            random_request(counted);
            if (counted)
                done++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        calm          = 1'b0;
        n_requests    = 0;
        n_lookups     = 0;
        n_ignored     = 0;
        n_bases       = 1;
        hot_dirs[0]   = 10'h000;
        hot_dirs[1]   = 10'h3FF;
        for (int i = 2; i < 8; i++)
            hot_dirs[i] = 10'($urandom);
        hot_slots[0]  = 10'h000;
        hot_slots[1]  = 10'h3FF;
        for (int i = 2; i < 4; i++)
            hot_slots[i] = 10'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // covers the directory clearing pass
        settle();
        apb_read();

        // Directed: reset state, top corner, mode switches, unmaps
        send_request(KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 2'd0);
        send_request(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, RING_USER);
        send_request(KIND_MAP_LARGE, 32'hFFC0_0000, 32'hFFFF_FFFF, RING_USER);
        send_request(KIND_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
        // small map over a large entry walks the table
        send_request(KIND_MAP_SMALL, 32'hFFFF_F000, 32'hFFFF_FFFF, RING_USER);
        send_request(KIND_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
        send_request(KIND_QUERY, 32'hFFC0_0000, 32'h0000_0000, 2'd0);
        send_request(KIND_MAP_SMALL, 32'h0000_0000, 32'h0000_0000, 2'd0);
        send_request(KIND_QUERY, 32'h0000_0FFF, 32'hFFFF_FFFF, 2'd1);
        send_request(KIND_MAP_SMALL, 32'h0000_1ABC, 32'h1234_5FFF, RING_USER);
        send_request(KIND_QUERY, 32'h0000_1000, 32'h0000_0000, 2'd2);
        send_request(KIND_UNMAP_SMALL, 32'h0000_0000, 32'hFFFF_FFFF, RING_USER);
        send_request(KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 2'd0);
        // small unmap on an entry still in large mode
        send_request(KIND_UNMAP_SMALL, 32'h0040_0000, 32'h0000_0000, 2'd0);
        send_request(KIND_UNMAP_LARGE, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
        send_request(KIND_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
        for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
            send_request(3'(k), $urandom, $urandom, 2'($urandom));
        send_request(KIND_QUERY, 32'h0000_0000, 32'h0000_0000, 2'd0);
        send_request(KIND_MAP_LARGE, 32'h1234_5678, 32'hABCD_EF01, 2'd2);
        send_request(KIND_QUERY, 32'h1234_5678, 32'h0000_0000, 2'd0);
        send_request(KIND_MAP_SMALL, 32'h1234_5678, 32'h8765_4321, 2'd1);
        send_request(KIND_QUERY, 32'h1234_5678, 32'h0000_0000, 2'd0);

        // Random phases over the base extremes and two more settings
        run_phase(32'h0000_0000, 1'b0);
        run_phase(32'hFFFF_F000, 1'b1);
        run_phase($urandom & SMALL_MASK, 1'b0);
        run_phase(TABLE_AREA_RESET, 1'b0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d page table requests (%0d lookups) plus %0d undefined kinds",
                 n_requests, n_lookups, n_ignored);
        $display("under %0d table area base settings, with random stalls on both streams",
                 n_bases);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
